[rtl/core/sth_pkg.sv]
// Shared constants, types and the sine quarter-wave table builder for the
// terrain height pipeline. No dependencies.
package sth_pkg;

   localparam int CHUNK_SIZE      = 16;
   localparam int SINE_TABLE_BITS = 10;

   localparam int TBL_N       = 1 << SINE_TABLE_BITS;
   localparam int SINE_DEPTH  = TBL_N + 1;
   localparam int IDX_W       = SINE_TABLE_BITS + 1;
   localparam int ROUND_HALF  = 1 << (29 - SINE_TABLE_BITS);

   // world coordinate width: chunk * size + sample, signed
   localparam int WORLD_W = 18 + $clog2(CHUNK_SIZE);

   // phase increments per world unit, in turns * 2^32
   localparam logic [31:0] K_005        = 32'd34178264;
   localparam logic [31:0] K_013        = 32'd88863486;
   localparam logic [31:0] K_007        = 32'd47849569;
   localparam logic [31:0] K_023        = 32'd157220013;
   localparam logic [31:0] K_017        = 32'd116206097;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIV [9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

   // phase slots
   localparam int NUM_PHASES = 4;
   localparam int PH_S1 = 0;
   localparam int PH_C1 = 1;
   localparam int PH_S2 = 2;
   localparam int PH_C3 = 3;

   localparam int TOTAL_W = 38;
   localparam longint ROUND_Q8 = 64'd2097152;
   localparam logic signed [15:0] HEIGHT_MAX = 16'sd8960;
   localparam logic signed [15:0] HEIGHT_MIN = -16'sd8960;

   // detail level grading
   localparam logic [16:0] DIST_NEAR = 17'd2;
   localparam logic [16:0] DIST_MID  = 17'd5;
   localparam logic [16:0] DIST_FAR  = 17'd10;
   localparam logic [1:0]  DETAIL_FINE   = 2'd0;
   localparam logic [1:0]  DETAIL_MID    = 2'd1;
   localparam logic [1:0]  DETAIL_LOW    = 2'd2;
   localparam logic [1:0]  DETAIL_COARSE = 2'd3;

   typedef logic [NUM_PHASES-1:0][31:0] phase_vec_type;
   typedef logic [NUM_PHASES-1:0][15:0] mag_vec_type;
   typedef logic [15:0] sine_rom_type [0:SINE_DEPTH-1];

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic s7;
   } stage_ctl_type;

   // Q15 sine over the first quadrant, Taylor series through x^19 in Q30
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          q;
      for (int i = 0; i < SINE_DEPTH; i++) begin
         x    = (longint'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 9; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if (k % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         q = (sum + 64'sd16384) >>> 15;
         if (q > 32768) begin
            q = 32768;
         end
         rom[i] = 16'(q);
      end
      return rom;
   endfunction

endpackage

[rtl/core/sth_phase.sv]
// Stages 1 to 3: world coordinates, phase products and the four phases.
// Depends on sth_pkg.
module sth_phase import sth_pkg::*; (
   input  logic                clock,
   input  stage_ctl_type       ctl,
   input  logic signed [15:0]  chunk_x,
   input  logic signed [15:0]  chunk_z,
   input  logic [3:0]          sample_x,
   input  logic [3:0]          sample_z,
   output phase_vec_type       phase
);

   localparam logic signed [WORLD_W-1:0] CHUNK_SIZE_W = WORLD_W'(CHUNK_SIZE);

   logic signed [WORLD_W-1:0] wx_in, wz_in, wx_ff, wz_ff;
   logic [31:0] wx32, wz32;
   logic [31:0] px005_ff, pz005_ff, px013_ff, pz007_ff, px023_ff, pz017_ff;
   phase_vec_type phase_in, phase_ff;

   // stage 1: world coordinates
   always_comb begin
      wx_in = WORLD_W'(WORLD_W'(chunk_x) * CHUNK_SIZE_W)
            + $signed({{(WORLD_W-4){1'b0}}, sample_x});
      wz_in = WORLD_W'(WORLD_W'(chunk_z) * CHUNK_SIZE_W)
            + $signed({{(WORLD_W-4){1'b0}}, sample_z});
   end

   always_ff @(posedge clock) begin
      if (ctl.s1) begin
         wx_ff <= wx_in;
         wz_ff <= wz_in;
      end
   end

   // stage 2: products, only the low 32 bits matter (phase wraps)
   assign wx32 = 32'(wx_ff);
   assign wz32 = 32'(wz_ff);

   always_ff @(posedge clock) begin
      if (ctl.s2) begin
         px005_ff <= 32'(wx32 * K_005);
         pz005_ff <= 32'(wz32 * K_005);
         px013_ff <= 32'(wx32 * K_013);
         pz007_ff <= 32'(wz32 * K_007);
         px023_ff <= 32'(wx32 * K_023);
         pz017_ff <= 32'(wz32 * K_017);
      end
   end

   // stage 3: phases, cosines get a quarter turn
   always_comb begin
      phase_in        = '0;
      phase_in[PH_S1] = px005_ff;
      phase_in[PH_C1] = pz005_ff + QUARTER_TURN;
      phase_in[PH_S2] = px013_ff + pz007_ff;
      phase_in[PH_C3] = px023_ff - pz017_ff + QUARTER_TURN;
   end

   always_ff @(posedge clock) begin
      if (ctl.s3) begin
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

[rtl/core/sth_sine_lookup.sv]
// Stages 4 and 5: quadrant fold, table index and registered table read.
// Depends on sth_pkg.
module sth_sine_lookup import sth_pkg::*; (
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  logic [31:0]   phase,
   output logic [15:0]   mag,
   output logic          neg
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [30:0]      rnd_sum;
   logic [IDX_W-1:0] idx_raw, idx_in, idx_ff;
   logic             neg4_ff, neg5_ff;
   logic [15:0]      mag_ff;

   // round the quadrant fraction to the table resolution, index runs 0..N
   always_comb begin
      rnd_sum = {1'b0, phase[29:0]} + 31'(ROUND_HALF);
      idx_raw = rnd_sum[30 -: IDX_W];
      idx_in  = phase[30] ? (IDX_W'(TBL_N) - idx_raw) : idx_raw;
   end

   always_ff @(posedge clock) begin
      if (ctl.s4) begin
         idx_ff  <= idx_in;
         neg4_ff <= phase[31];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s5) begin
         mag_ff  <= SINE_ROM[idx_ff];
         neg5_ff <= neg4_ff;
      end
   end

   assign mag = mag_ff;
   assign neg = neg5_ff;

endmodule

[rtl/core/sth_combine.sv]
// Stages 6 and 7: signed sines, weighted sum, Q8 rounding and saturation.
// Depends on sth_pkg.
module sth_combine import sth_pkg::*; (
   input  logic                  clock,
   input  stage_ctl_type         ctl,
   input  mag_vec_type           mag,
   input  logic [NUM_PHASES-1:0] neg,
   output logic [14:0]           height
);

   logic signed [16:0] sval [NUM_PHASES];
   logic signed [33:0] prod_in, prod_ff;
   logic signed [20:0] lin_in, lin_ff;
   logic signed [TOTAL_W-1:0] total;
   logic signed [15:0] h_raw, h_sat;
   logic [14:0] height_ff;

   // stage 6: s1*c1 and the linear part 10*s2 + 5*c3
   always_comb begin
      for (int i = 0; i < NUM_PHASES; i++) begin
         sval[i] = neg[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
      end
      prod_in = 34'(sval[PH_S1]) * 34'(sval[PH_C1]);
      lin_in  = 21'(sval[PH_S2]) * 21'sd10 + 21'(sval[PH_C3]) * 21'sd5;
   end

   always_ff @(posedge clock) begin
      if (ctl.s6) begin
         prod_ff <= prod_in;
         lin_ff  <= lin_in;
      end
   end

   // stage 7: total in Q30, round half up to Q8
   always_comb begin
      total = (TOTAL_W'(prod_ff) <<< 4) + (TOTAL_W'(prod_ff) <<< 2)
            + (TOTAL_W'(lin_ff) <<< 15) + TOTAL_W'(ROUND_Q8);
      h_raw = 16'(total >>> 22);
      if (h_raw > HEIGHT_MAX) begin
         h_sat = HEIGHT_MAX;
      end else if (h_raw < HEIGHT_MIN) begin
         h_sat = HEIGHT_MIN;
      end else begin
         h_sat = h_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s7) begin
         height_ff <= 15'(h_sat);
      end
   end

   assign height = height_ff;

endmodule

[rtl/core/sinusoid_terrain_height_top.sv]
// Terrain height sampler top level: pipeline control, detail level and
// stage wiring. Depends on sth_pkg, sth_phase, sth_sine_lookup, sth_combine.
//
// Usage:
//   req_* carries one sample request per transfer (chunk coordinates and the
//   sample position inside the chunk). rsp_* returns one result per request,
//   in order: the Q8 terrain height and the chunk's detail level.
//   The work runs through seven register stages: world coordinates, phase
//   multipliers, phase sums, table index, table read, product,
//   sum/round/saturate. The first stage loads at the accepting edge, and the
//   result moves through the later stages in order; rsp_tvalid rises when it
//   reaches the last stage, and it transfers once rsp_tready is high.
//   Throughput is one transfer per cycle while rsp_tready is high; the
//   table read and the multipliers are fully pipelined.
//   Each stage holds a valid bit and advances when it is empty or the next
//   stage advances, so bubbles close up and requests keep being taken while
//   a result waits on rsp_tready; when all seven stages are full and the
//   receiver stalls, req_tready drops and nothing is lost or repeated.
//   Synchronous reset clears all valid bits; results in flight are dropped.
module sinusoid_terrain_height_top import sth_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] chunk_x, [31:16] chunk_z, [35:32] sample_x, [39:36] sample_z
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [14:0] height, [16:15] detail_level, [23:17] zero
   output logic [23:0] rsp_tdata
);

   localparam int NUM_STAGES = 7;

   logic [NUM_STAGES:1]   valid_ff, valid_in;
   logic [NUM_STAGES+1:1] adv;
   stage_ctl_type         ctl;

   logic signed [15:0] chunk_x, chunk_z;
   logic [16:0] abs_x, abs_z, manhattan;
   logic [1:0]  lod_in;
   logic [1:0]  lod_ff [1:NUM_STAGES];

   phase_vec_type         phase;
   mag_vec_type           mag;
   logic [NUM_PHASES-1:0] neg;
   logic [14:0]           height;

   // stage advance chain, output end first
   always_comb begin
      adv[NUM_STAGES+1] = rsp_tready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[1] = adv[1] ? req_tvalid : valid_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
      ctl.s1 = adv[1];
      ctl.s2 = adv[2];
      ctl.s3 = adv[3];
      ctl.s4 = adv[4];
      ctl.s5 = adv[5];
      ctl.s6 = adv[6];
      ctl.s7 = adv[7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[1];
   assign rsp_tvalid = valid_ff[NUM_STAGES];

   assign chunk_x = $signed(req_tdata[15:0]);
   assign chunk_z = $signed(req_tdata[31:16]);

   // detail level from Manhattan distance of the chunk
   always_comb begin
      abs_x = chunk_x[15] ? (17'd0 - 17'(chunk_x)) : 17'(chunk_x);
      abs_z = chunk_z[15] ? (17'd0 - 17'(chunk_z)) : 17'(chunk_z);
      manhattan = abs_x + abs_z;
      if (manhattan <= DIST_NEAR) begin
         lod_in = DETAIL_FINE;
      end else if (manhattan <= DIST_MID) begin
         lod_in = DETAIL_MID;
      end else if (manhattan <= DIST_FAR) begin
         lod_in = DETAIL_LOW;
      end else begin
         lod_in = DETAIL_COARSE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         lod_ff[1] <= lod_in;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
         if (adv[k]) begin
            lod_ff[k] <= lod_ff[k-1];
         end
      end
   end

   sth_phase u_phase (
      .clock    (clock),
      .ctl      (ctl),
      .chunk_x  (chunk_x),
      .chunk_z  (chunk_z),
      .sample_x (req_tdata[35:32]),
      .sample_z (req_tdata[39:36]),
      .phase    (phase)
   );

   for (genvar g = 0; g < NUM_PHASES; g++) begin : g_lookup
      sth_sine_lookup u_lookup (
         .clock (clock),
         .ctl   (ctl),
         .phase (phase[g]),
         .mag   (mag[g]),
         .neg   (neg[g])
      );
   end

   sth_combine u_combine (
      .clock  (clock),
      .ctl    (ctl),
      .mag    (mag),
      .neg    (neg),
      .height (height)
   );

   assign rsp_tdata = {7'd0, lod_ff[NUM_STAGES], height};

   // items in flight change only by transfers on the two channels
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         $countones(valid_ff) == $past($countones(valid_ff))
            + int'($past(req_tvalid && req_tready))
            - int'($past(rsp_tvalid && rsp_tready)))
      else $error("pipeline occupancy does not match transfers");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      valid_ff == '0 |-> req_tready)
      else $error("empty pipeline refuses a request");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[14:0]) <= 15'sd8960 &&
                      $signed(rsp_tdata[14:0]) >= -15'sd8960))
      else $error("height outside saturation range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
